@@ design/absolute_to_relative_mouse_reports_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the absolute-to-relative mouse report block.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ABSOLUTE_TO_RELATIVE_MOUSE_REPORTS_DEFINES_SVH
`define ABSOLUTE_TO_RELATIVE_MOUSE_REPORTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A2R_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define A2R_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/a2r_pkg.sv @@
// ----------------------------------------------------------------------------
// a2r_pkg
// Types, constants and the control program of the mouse report generator.
// ----------------------------------------------------------------------------
package a2r_pkg;

    localparam int unsigned SCREEN_SPAN_X = 550;
    localparam int unsigned SCREEN_SPAN_Y = 400;
    localparam int unsigned INPUT_SPAN    = 10000;

    localparam int unsigned RAW_W   = 14;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned GAP_W   = POS_W + 1;
    localparam int unsigned IDLE_W  = 4;
    localparam int unsigned CFG_W   = 4;
    localparam int unsigned DELTA_W = 8;
    localparam int unsigned BTN_W   = 2;
    localparam int unsigned EV_W    = 3;
    localparam int unsigned STEP    = 127;

    // Scaling: p = raw * span, then p / INPUT_SPAN by a reciprocal that is
    // at most one low, followed by a single correcting compare.
    localparam int unsigned SPAN_MAX  = (SCREEN_SPAN_X > SCREEN_SPAN_Y) ?
                                        SCREEN_SPAN_X : SCREEN_SPAN_Y;
    localparam int unsigned PROD_W    = $clog2((INPUT_SPAN - 1) * SPAN_MAX + 1);
    localparam int unsigned RECIP     = (1 << PROD_W) / INPUT_SPAN;
    localparam int unsigned MUL_A_W   = PROD_W;
    localparam int unsigned MUL_B_W   = RAW_W;
    localparam int unsigned MUL_W     = MUL_A_W + MUL_B_W;

    localparam logic [BTN_W-1:0] BTN_NONE  = 2'd0;
    localparam logic [BTN_W-1:0] BTN_LEFT  = 2'd1;
    localparam logic [BTN_W-1:0] BTN_RIGHT = 2'd2;

    localparam logic [EV_W-1:0] EV_PRESS_LEFT    = 3'd1;
    localparam logic [EV_W-1:0] EV_RELEASE_LEFT  = 3'd2;
    localparam logic [EV_W-1:0] EV_PRESS_RIGHT   = 3'd3;
    localparam logic [EV_W-1:0] EV_RELEASE_RIGHT = 3'd4;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_AFTER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_COUNT = 1'b1;

    typedef struct packed {
        logic [EV_W-1:0]  button_event;
        logic [RAW_W-1:0] x_raw;
        logic [RAW_W-1:0] y_raw;
    } in_item_t;

    typedef struct packed {
        logic [BTN_W-1:0]          buttons;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic                      last;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_WAIT  = 4'd0,
        OP_MULX  = 4'd1,
        OP_MULY  = 4'd2,
        OP_RCP   = 4'd3,
        OP_BACK  = 4'd4,
        OP_FIXX  = 4'd5,
        OP_FIXY  = 4'd6,
        OP_WALKX = 4'd7,
        OP_WALKY = 4'd8,
        OP_FINAL = 4'd9,
        OP_HOME  = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT   = 3'd0,
        C_FIRE   = 3'd1,
        C_GAPX   = 3'd2,
        C_GAPY   = 3'd3,
        C_HOMING = 3'd4,
        C_MORE   = 3'd5
    } cond_t;

    localparam int unsigned PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t A_WAIT  = 4'd0;
    localparam pc_t A_MULX  = 4'd1;
    localparam pc_t A_RCPX  = 4'd2;
    localparam pc_t A_BACKX = 4'd3;
    localparam pc_t A_FIXX  = 4'd4;
    localparam pc_t A_MULY  = 4'd5;
    localparam pc_t A_RCPY  = 4'd6;
    localparam pc_t A_BACKY = 4'd7;
    localparam pc_t A_FIXY  = 4'd8;
    localparam pc_t A_WALKX = 4'd9;
    localparam pc_t A_WALKY = 4'd10;
    localparam pc_t A_FINAL = 4'd11;
    localparam pc_t A_HOME  = 4'd12;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic fire;
        logic gap_x_big;
        logic gap_y_big;
        logic home_go;
        logic more;
        logic hold;
    } stat_t;

    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t c;
        case (pc)
            A_WAIT:  c = '{OP_WAIT,  C_FIRE,   A_WAIT};
            A_MULX:  c = '{OP_MULX,  C_NEXT,   A_WAIT};
            A_RCPX:  c = '{OP_RCP,   C_NEXT,   A_WAIT};
            A_BACKX: c = '{OP_BACK,  C_NEXT,   A_WAIT};
            A_FIXX:  c = '{OP_FIXX,  C_NEXT,   A_WAIT};
            A_MULY:  c = '{OP_MULY,  C_NEXT,   A_WAIT};
            A_RCPY:  c = '{OP_RCP,   C_NEXT,   A_WAIT};
            A_BACKY: c = '{OP_BACK,  C_NEXT,   A_WAIT};
            A_FIXY:  c = '{OP_FIXY,  C_NEXT,   A_WAIT};
            A_WALKX: c = '{OP_WALKX, C_GAPX,   A_WAIT};
            A_WALKY: c = '{OP_WALKY, C_GAPY,   A_WAIT};
            A_FINAL: c = '{OP_FINAL, C_HOMING, A_WAIT};
            A_HOME:  c = '{OP_HOME,  C_MORE,   A_WAIT};
            default: c = '{OP_WAIT,  C_NEXT,   A_WAIT};
        endcase
        return c;
    endfunction

endpackage

@@ design/a2r_seq.sv @@
// ----------------------------------------------------------------------------
// a2r_seq
// Step counter and control store; issues one control word per cycle, holding the step while stat.hold is set.
// ----------------------------------------------------------------------------
module a2r_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  a2r_pkg::stat_t   stat,
    output a2r_pkg::ctrl_t   ctrl
);

    a2r_pkg::pc_t pc_reg;
    a2r_pkg::pc_t pc_next;
    a2r_pkg::pc_t pc_inc;

    assign ctrl   = a2r_pkg::ucode(pc_reg);
    assign pc_inc = a2r_pkg::pc_t'(pc_reg + 1'b1);

    always_comb
    begin
        pc_next = pc_reg;
        if (!stat.hold)
        begin
            case (ctrl.cond)
                a2r_pkg::C_NEXT:   pc_next = pc_inc;
                a2r_pkg::C_FIRE:   pc_next = stat.fire ? pc_inc : pc_reg;
                a2r_pkg::C_GAPX:   pc_next = stat.gap_x_big ? pc_reg : pc_inc;
                a2r_pkg::C_GAPY:   pc_next = stat.gap_y_big ? pc_reg : pc_inc;
                a2r_pkg::C_HOMING: pc_next = stat.home_go ? pc_inc : ctrl.target;
                a2r_pkg::C_MORE:   pc_next = stat.more ? pc_reg : ctrl.target;
                default:           pc_next = a2r_pkg::A_WAIT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= a2r_pkg::A_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ design/absolute_to_relative_mouse_reports.sv @@
// An item is taken only while the sequencer waits; it then runs the eight scaling steps,
// the x and y step reports, the final report and any homing reports, then takes the next.
// The first report reaches the output register only after the scaling steps.
// The pace is set by the single shared multiplier and one report a cycle when not stalled.
// Asynchronous active-low reset restores position, buttons, idle count and both registers.
// ----------------------------------------------------------------------------
// absolute_to_relative_mouse_reports
// Turns absolute pointer events into a run of relative mouse reports with
// periodic homing, under control of a small microcoded sequencer.
// ----------------------------------------------------------------------------
`include "absolute_to_relative_mouse_reports_defines.svh"

module absolute_to_relative_mouse_reports (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  a2r_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output a2r_pkg::out_item_t                  out_data,
    input  logic                                cfg_write,
    input  logic [a2r_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [a2r_pkg::CFG_W-1:0]           cfg_data
);

    localparam logic signed [a2r_pkg::GAP_W-1:0] STEP_G =
        a2r_pkg::GAP_W'(a2r_pkg::STEP);
    localparam logic signed [a2r_pkg::DELTA_W-1:0] STEP_POS =
        a2r_pkg::DELTA_W'(a2r_pkg::STEP);
    localparam logic signed [a2r_pkg::DELTA_W-1:0] STEP_NEG = -STEP_POS;

    a2r_pkg::ctrl_t ctrl;
    a2r_pkg::stat_t stat;

    // Working values.
    logic [a2r_pkg::RAW_W-1:0]  rx_reg, rx_next, ry_reg, ry_next;
    logic [a2r_pkg::PROD_W-1:0] p_reg, p_next, b_reg, b_next;
    logic [a2r_pkg::POS_W-1:0]  q_reg, q_next, tx_reg, tx_next, ty_reg, ty_next;

    // Block state and configuration.
    logic [a2r_pkg::POS_W-1:0]  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic                       left_reg, left_next, right_reg, right_next;
    logic [a2r_pkg::IDLE_W-1:0] idle_reg, idle_next;
    logic [a2r_pkg::CFG_W-1:0]  hcnt_reg, hcnt_next;
    logic [a2r_pkg::CFG_W-1:0]  ham_reg, ham_next, hrc_reg, hrc_next;

    logic                       out_valid_reg, out_valid_next;
    a2r_pkg::out_item_t         out_reg, out_next;

    logic                       in_fire, out_fire, slot_free, emit, out_load;
    logic [a2r_pkg::MUL_A_W-1:0] mul_a;
    logic [a2r_pkg::MUL_B_W-1:0] mul_b;
    logic [a2r_pkg::MUL_W-1:0]   prod;
    logic [a2r_pkg::PROD_W-1:0]  rem;
    logic [a2r_pkg::POS_W-1:0]   q_fix;
    logic [a2r_pkg::RAW_W-1:0]   x_sat, y_sat;
    logic signed [a2r_pkg::GAP_W-1:0] gap_x, gap_y;
    logic                        gap_x_big, gap_y_big;
    logic [a2r_pkg::IDLE_W:0]    idle_inc;
    logic                        home, home_go;
    logic [a2r_pkg::BTN_W-1:0]   btn;
    a2r_pkg::out_item_t          emit_item;

    a2r_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign in_stall  = (ctrl.op != a2r_pkg::OP_WAIT);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign x_sat = (in_data.x_raw >= a2r_pkg::RAW_W'(a2r_pkg::INPUT_SPAN)) ?
                   a2r_pkg::RAW_W'(a2r_pkg::INPUT_SPAN - 1) : in_data.x_raw;
    assign y_sat = (in_data.y_raw >= a2r_pkg::RAW_W'(a2r_pkg::INPUT_SPAN)) ?
                   a2r_pkg::RAW_W'(a2r_pkg::INPUT_SPAN - 1) : in_data.y_raw;

    // One shared multiplier, its operands chosen by the current step.
    always_comb
    begin
        case (ctrl.op)
            a2r_pkg::OP_MULX:
            begin
                mul_a = a2r_pkg::MUL_A_W'(rx_reg);
                mul_b = a2r_pkg::MUL_B_W'(a2r_pkg::SCREEN_SPAN_X);
            end
            a2r_pkg::OP_MULY:
            begin
                mul_a = a2r_pkg::MUL_A_W'(ry_reg);
                mul_b = a2r_pkg::MUL_B_W'(a2r_pkg::SCREEN_SPAN_Y);
            end
            a2r_pkg::OP_RCP:
            begin
                mul_a = p_reg;
                mul_b = a2r_pkg::MUL_B_W'(a2r_pkg::RECIP);
            end
            a2r_pkg::OP_BACK:
            begin
                mul_a = a2r_pkg::MUL_A_W'(q_reg);
                mul_b = a2r_pkg::MUL_B_W'(a2r_pkg::INPUT_SPAN);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod  = a2r_pkg::MUL_W'(mul_a) * a2r_pkg::MUL_W'(mul_b);
    // The reciprocal quotient is at most one low; the remainder tells.
    assign rem   = p_reg - b_reg;
    assign q_fix = q_reg + a2r_pkg::POS_W'(rem >= a2r_pkg::PROD_W'(a2r_pkg::INPUT_SPAN));

    assign gap_x = $signed({1'b0, tx_reg}) - $signed({1'b0, cur_x_reg});
    assign gap_y = $signed({1'b0, ty_reg}) - $signed({1'b0, cur_y_reg});
    assign gap_x_big = (gap_x > STEP_G) || (gap_x < -STEP_G);
    assign gap_y_big = (gap_y > STEP_G) || (gap_y < -STEP_G);

    assign idle_inc = {1'b0, idle_reg} + 1'b1;
    assign home     = !left_reg && (idle_inc > {1'b0, ham_reg});
    assign home_go  = home && (hrc_reg != '0);
    assign btn      = left_reg ? a2r_pkg::BTN_LEFT :
                      (right_reg ? a2r_pkg::BTN_RIGHT : a2r_pkg::BTN_NONE);

    always_comb
    begin
        emit      = 1'b0;
        emit_item = '{a2r_pkg::BTN_NONE, '0, '0, 1'b0};
        case (ctrl.op)
            a2r_pkg::OP_WALKX:
            begin
                emit      = gap_x_big;
                emit_item = '{a2r_pkg::BTN_NONE,
                              gap_x[a2r_pkg::GAP_W-1] ? STEP_NEG : STEP_POS, '0, 1'b0};
            end
            a2r_pkg::OP_WALKY:
            begin
                emit      = gap_y_big;
                emit_item = '{a2r_pkg::BTN_NONE, '0,
                              gap_y[a2r_pkg::GAP_W-1] ? STEP_NEG : STEP_POS, 1'b0};
            end
            a2r_pkg::OP_FINAL:
            begin
                emit      = 1'b1;
                emit_item = '{btn, gap_x[a2r_pkg::DELTA_W-1:0],
                              gap_y[a2r_pkg::DELTA_W-1:0], !home_go};
            end
            a2r_pkg::OP_HOME:
            begin
                emit      = 1'b1;
                emit_item = '{a2r_pkg::BTN_NONE, STEP_NEG, STEP_NEG,
                              hcnt_reg == a2r_pkg::CFG_W'(1)};
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign out_load = emit && slot_free;

    assign stat.fire      = in_fire;
    assign stat.gap_x_big = gap_x_big;
    assign stat.gap_y_big = gap_y_big;
    assign stat.home_go   = home_go;
    assign stat.more      = hcnt_reg > a2r_pkg::CFG_W'(1);
    assign stat.hold      = emit && !slot_free;

    always_comb
    begin
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        b_next     = b_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        left_next  = left_reg;
        right_next = right_reg;
        idle_next  = idle_reg;
        hcnt_next  = hcnt_reg;
        ham_next   = ham_reg;
        hrc_next   = hrc_reg;

        case (ctrl.op)
            a2r_pkg::OP_WAIT:
            begin
                if (in_fire)
                begin
                    rx_next = x_sat;
                    ry_next = y_sat;
                    case (in_data.button_event)
                        a2r_pkg::EV_PRESS_LEFT:    left_next  = 1'b1;
                        a2r_pkg::EV_RELEASE_LEFT:  left_next  = 1'b0;
                        a2r_pkg::EV_PRESS_RIGHT:   right_next = 1'b1;
                        a2r_pkg::EV_RELEASE_RIGHT: right_next = 1'b0;
                        default:                   ;
                    endcase
                end
            end
            a2r_pkg::OP_MULX, a2r_pkg::OP_MULY:
            begin
                p_next = prod[a2r_pkg::PROD_W-1:0];
            end
            a2r_pkg::OP_RCP:
            begin
                q_next = prod[a2r_pkg::PROD_W +: a2r_pkg::POS_W];
            end
            a2r_pkg::OP_BACK:
            begin
                b_next = prod[a2r_pkg::PROD_W-1:0];
            end
            a2r_pkg::OP_FIXX:
            begin
                tx_next = q_fix;
            end
            a2r_pkg::OP_FIXY:
            begin
                ty_next = q_fix;
            end
            a2r_pkg::OP_WALKX:
            begin
                if (out_load)
                begin
                    cur_x_next = gap_x[a2r_pkg::GAP_W-1] ?
                                 cur_x_reg - a2r_pkg::POS_W'(a2r_pkg::STEP) :
                                 cur_x_reg + a2r_pkg::POS_W'(a2r_pkg::STEP);
                end
            end
            a2r_pkg::OP_WALKY:
            begin
                if (out_load)
                begin
                    cur_y_next = gap_y[a2r_pkg::GAP_W-1] ?
                                 cur_y_reg - a2r_pkg::POS_W'(a2r_pkg::STEP) :
                                 cur_y_reg + a2r_pkg::POS_W'(a2r_pkg::STEP);
                end
            end
            a2r_pkg::OP_FINAL:
            begin
                if (out_load)
                begin
                    // A homing move leaves the pointer at the origin.
                    cur_x_next = home ? '0 : tx_reg;
                    cur_y_next = home ? '0 : ty_reg;
                    hcnt_next  = hrc_reg;
                    if (!left_reg)
                    begin
                        idle_next = home ? '0 : idle_inc[a2r_pkg::IDLE_W-1:0];
                    end
                end
            end
            a2r_pkg::OP_HOME:
            begin
                if (out_load)
                begin
                    hcnt_next = hcnt_reg - 1'b1;
                end
            end
            default:
            begin
                rx_next = rx_reg;
            end
        endcase

        if (cfg_write)
        begin
            case (cfg_index)
                a2r_pkg::CFG_HOME_AFTER: ham_next = cfg_data;
                a2r_pkg::CFG_HOME_COUNT: hrc_next = cfg_data;
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_item;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            left_reg      <= 1'b0;
            right_reg     <= 1'b0;
            idle_reg      <= '0;
            hcnt_reg      <= '0;
            ham_reg       <= a2r_pkg::CFG_W'(3);
            hrc_reg       <= a2r_pkg::CFG_W'(10);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            idle_reg      <= idle_next;
            hcnt_reg      <= hcnt_next;
            ham_reg       <= ham_next;
            hrc_reg       <= hrc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        p_reg   <= p_next;
        q_reg   <= q_next;
        b_reg   <= b_next;
        tx_reg  <= tx_next;
        ty_reg  <= ty_next;
        out_reg <= out_next;
    end

    `A2R_CHECK_NOW(a_final_in_reach, ctrl.op == a2r_pkg::OP_FINAL,
        !gap_x_big && !gap_y_big, "final report gap exceeds one step")
    `A2R_CHECK_NOW(a_home_count_live, ctrl.op == a2r_pkg::OP_HOME,
        hcnt_reg != '0, "homing step entered with an empty count")
    `A2R_CHECK_NEXT(a_no_report_after_accept, in_fire,
        !out_load, "report produced before scaling finished")
    `A2R_CHECK_NEXT(a_idle_after_last_home,
        ctrl.op == a2r_pkg::OP_HOME && out_load && hcnt_reg == a2r_pkg::CFG_W'(1),
        ctrl.op == a2r_pkg::OP_WAIT, "sequencer did not return after homing")

endmodule

@@ dv/absolute_to_relative_mouse_reports_test.sv @@
// ----------------------------------------------------------------------------
// absolute_to_relative_mouse_reports_test
// Sends pointer events to the mouse report block and predicts every report in
// a scoreboard that tracks position, held buttons and the idle move count.
// Directed events run first, then random phases under several register
// settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module absolute_to_relative_mouse_reports_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STRIDE = int'(a2r_pkg::STEP);
    localparam logic [a2r_pkg::EV_W-1:0] EV_NO_BUTTON = 3'd0;
    localparam logic [a2r_pkg::EV_W-1:0] EV_BAD_FIRST = 3'd5;
    localparam logic [a2r_pkg::EV_W-1:0] EV_BAD_MID   = 3'd6;
    localparam logic [a2r_pkg::EV_W-1:0] EV_BAD_LAST  = 3'd7;
    localparam int unsigned RAW_TOP  = a2r_pkg::INPUT_SPAN - 1;
    localparam int unsigned RAW_FULL = (1 << a2r_pkg::RAW_W) - 1;
    localparam int unsigned HOLD_AT     = 55;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASES      = 5;
    localparam int unsigned PHASE_ITEMS = 92;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    a2r_pkg::in_item_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    a2r_pkg::out_item_t            out_data;
    logic                          cfg_write;
    logic [a2r_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [a2r_pkg::CFG_W-1:0]     cfg_data;

    class report_scoreboard;
        logic [a2r_pkg::CFG_W-1:0] home_after;
        logic [a2r_pkg::CFG_W-1:0] home_count;
        int                        pos_x;
        int                        pos_y;
        bit                        left_down;
        bit                        right_down;
        int unsigned               idle_count;
        a2r_pkg::out_item_t        due_reports[$];
        int unsigned               errors;
        int unsigned               events;
        int unsigned               reports_checked;
        int unsigned               walk_steps;
        int unsigned               homing_runs;

        function new();
            home_after = 4'd3;
            home_count = 4'd10;
            pos_x = 0;
            pos_y = 0;
            left_down = 1'b0;
            right_down = 1'b0;
            idle_count = 0;
            errors = 0;
            events = 0;
            reports_checked = 0;
            walk_steps = 0;
            homing_runs = 0;
        endfunction

        function void write_reg(logic [a2r_pkg::CFG_IDX_W-1:0] idx,
                                logic [a2r_pkg::CFG_W-1:0] val);
            case (idx)
                a2r_pkg::CFG_HOME_AFTER: home_after = val;
                a2r_pkg::CFG_HOME_COUNT: home_count = val;
                default: ;
            endcase
        endfunction

        function int scale(logic [a2r_pkg::RAW_W-1:0] raw, int unsigned span);
            int unsigned r;
            r = raw;
            if (r >= a2r_pkg::INPUT_SPAN)
                r = a2r_pkg::INPUT_SPAN - 1;
            return int'((r * span) / a2r_pkg::INPUT_SPAN);
        endfunction

        function void push_report(logic [a2r_pkg::BTN_W-1:0] btn, int dx, int dy, bit fin);
            a2r_pkg::out_item_t r;
            r.buttons = btn;
            r.delta_x = dx[a2r_pkg::DELTA_W-1:0];
            r.delta_y = dy[a2r_pkg::DELTA_W-1:0];
            r.last    = fin;
            due_reports.push_back(r);
        endfunction

        // Works out every report that one accepted event causes.
        function void note_event(a2r_pkg::in_item_t ev);
            int                        tx;
            int                        ty;
            int                        d;
            int unsigned               cnt;
            bit                        home;
            logic [a2r_pkg::BTN_W-1:0] btn;
            events++;
            case (ev.button_event)
                a2r_pkg::EV_PRESS_LEFT:    left_down = 1'b1;
                a2r_pkg::EV_RELEASE_LEFT:  left_down = 1'b0;
                a2r_pkg::EV_PRESS_RIGHT:   right_down = 1'b1;
                a2r_pkg::EV_RELEASE_RIGHT: right_down = 1'b0;
                default: ;
            endcase
            tx = scale(ev.x_raw, a2r_pkg::SCREEN_SPAN_X);
            ty = scale(ev.y_raw, a2r_pkg::SCREEN_SPAN_Y);
            while (tx - pos_x > STRIDE || pos_x - tx > STRIDE)
            begin
                d = (tx > pos_x) ? STRIDE : -STRIDE;
                pos_x += d;
                push_report(a2r_pkg::BTN_NONE, d, 0, 1'b0);
                walk_steps++;
            end
            while (ty - pos_y > STRIDE || pos_y - ty > STRIDE)
            begin
                d = (ty > pos_y) ? STRIDE : -STRIDE;
                pos_y += d;
                push_report(a2r_pkg::BTN_NONE, 0, d, 1'b0);
                walk_steps++;
            end
            btn = left_down ? a2r_pkg::BTN_LEFT :
                  (right_down ? a2r_pkg::BTN_RIGHT : a2r_pkg::BTN_NONE);
            home = 1'b0;
            if (!left_down)
            begin
                // The count is compared one bit wider, so it can exceed fifteen.
                cnt = idle_count + 1;
                if (cnt > home_after)
                begin
                    home = 1'b1;
                    idle_count = 0;
                end
                else
                begin
                    idle_count = cnt & 4'hF;
                end
            end
            push_report(btn, tx - pos_x, ty - pos_y, !(home && home_count != 0));
            pos_x = tx;
            pos_y = ty;
            if (home)
            begin
                homing_runs++;
                for (int i = 0; i < home_count; i++)
                    push_report(a2r_pkg::BTN_NONE, -STRIDE, -STRIDE, i + 1 == home_count);
                pos_x = 0;
                pos_y = 0;
            end
        endfunction

        function void compare_field(string name, logic signed [8:0] want,
                                    logic signed [8:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(a2r_pkg::out_item_t got);
            a2r_pkg::out_item_t want;
            reports_checked++;
            if (due_reports.size() == 0)
            begin
                $error("report with nothing outstanding: buttons %0d dx %0d dy %0d last %0d",
                       got.buttons, got.delta_x, got.delta_y, got.last);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            compare_field("buttons", {7'd0, want.buttons}, {7'd0, got.buttons});
            compare_field("delta_x", {want.delta_x[7], want.delta_x},
                          {got.delta_x[7], got.delta_x});
            compare_field("delta_y", {want.delta_y[7], want.delta_y},
                          {got.delta_y[7], got.delta_y});
            compare_field("last", {8'd0, want.last}, {8'd0, got.last});
        endfunction

        function int unsigned pending();
            return due_reports.size();
        endfunction
    endclass

    report_scoreboard sb = new();

    bit                         calm = 1'b0;
    bit                         offering = 1'b0;
    bit                         held_off = 1'b0;
    int unsigned                items_in = 0;
    int unsigned                settings_used = 1;
    logic [a2r_pkg::RAW_W-1:0]  last_x = '0;
    logic [a2r_pkg::RAW_W-1:0]  last_y = '0;

    absolute_to_relative_mouse_reports u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly back to back, now and then a short gap, rarely a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic a2r_pkg::in_item_t make_item(logic [a2r_pkg::EV_W-1:0] ev,
                                                    int unsigned x, int unsigned y);
        a2r_pkg::in_item_t it;
        it.button_event = ev;
        it.x_raw = x[a2r_pkg::RAW_W-1:0];
        it.y_raw = y[a2r_pkg::RAW_W-1:0];
        return it;
    endfunction

    function automatic logic [a2r_pkg::EV_W-1:0] pick_event();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return EV_NO_BUTTON;
        if (r < 62) return a2r_pkg::EV_PRESS_LEFT;
        if (r < 75) return a2r_pkg::EV_RELEASE_LEFT;
        if (r < 84) return a2r_pkg::EV_PRESS_RIGHT;
        if (r < 93) return a2r_pkg::EV_RELEASE_RIGHT;
        return a2r_pkg::EV_W'($urandom_range(EV_BAD_LAST, EV_BAD_FIRST));
    endfunction

    function automatic int unsigned pick_edge();
        case ($urandom_range(3))
            0: return 0;
            1: return RAW_TOP;
            2: return a2r_pkg::INPUT_SPAN;
            default: return $urandom_range(RAW_FULL, a2r_pkg::INPUT_SPAN);
        endcase
    endfunction

    function automatic int unsigned nudge(logic [a2r_pkg::RAW_W-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(400)) - 200;
        if (v < 0) v = 0;
        if (v > int'(RAW_TOP)) v = int'(RAW_TOP);
        return unsigned'(v);
    endfunction

    // Far jumps make long walks; nudges keep the pointer within one report unless it was just homed.
    function a2r_pkg::in_item_t random_item();
        a2r_pkg::in_item_t it;
        int unsigned       r;
        r = $urandom_range(99);
        if (r < 12)
            it = make_item(pick_event(), pick_edge(), pick_edge());
        else if (r < 50)
            it = make_item(pick_event(), nudge(last_x), nudge(last_y));
        else if (r < 95)
            it = make_item(pick_event(), $urandom_range(RAW_TOP), $urandom_range(RAW_TOP));
        else
            it = make_item(pick_event(), $urandom_range(RAW_FULL), $urandom_range(RAW_FULL));
        last_x = it.x_raw;
        last_y = it.y_raw;
        return it;
    endfunction

    task automatic send_item(input a2r_pkg::in_item_t it);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            if (offering)
                in_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        offering = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_event(it);
        items_in++;
    endtask

    task automatic drain();
        if (offering)
            in_valid <= 1'b0;
        offering = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_registers(input logic [a2r_pkg::CFG_W-1:0] after_moves,
                                 input logic [a2r_pkg::CFG_W-1:0] report_count);
        cfg_write <= 1'b1;
        cfg_index <= a2r_pkg::CFG_HOME_AFTER;
        cfg_data  <= after_moves;
        @(posedge clk);
        cfg_index <= a2r_pkg::CFG_HOME_COUNT;
        cfg_data  <= report_count;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(a2r_pkg::CFG_HOME_AFTER, after_moves);
        sb.write_reg(a2r_pkg::CFG_HOME_COUNT, report_count);
        settings_used++;
    endtask

    // Receiver: random stalls, plus one long hold-off while the sender keeps going.
    initial
    begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_report(out_data);
            if (!held_off && items_in >= HOLD_AT)
            begin
                held_off = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0)
                stall_left = idle_gap();
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        logic [a2r_pkg::CFG_W-1:0] after_moves;
        logic [a2r_pkg::CFG_W-1:0] report_count;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= a2r_pkg::CFG_HOME_AFTER;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed events under the reset register values.
        send_item(make_item(EV_NO_BUTTON, 0, 0));
        send_item(make_item(a2r_pkg::EV_PRESS_LEFT, RAW_TOP, RAW_TOP));
        send_item(make_item(EV_NO_BUTTON, 0, 0));
        send_item(make_item(a2r_pkg::EV_PRESS_RIGHT, RAW_FULL, RAW_FULL));
        send_item(make_item(a2r_pkg::EV_RELEASE_LEFT, 5000, 5000));
        send_item(make_item(a2r_pkg::EV_RELEASE_RIGHT, a2r_pkg::INPUT_SPAN, 0));
        send_item(make_item(EV_BAD_FIRST, 8191, 8192));
        send_item(make_item(EV_BAD_MID, 14'h2AAA, 14'h1555));
        send_item(make_item(EV_BAD_LAST, 14'h1555, 14'h2AAA));
        // The first event puts the pointer at the origin: gaps of exactly one step, then one more.
        send_item(make_item(a2r_pkg::EV_PRESS_LEFT, 0, 0));
        send_item(make_item(EV_NO_BUTTON, 2310, 3175));
        send_item(make_item(EV_NO_BUTTON, 0, 0));
        send_item(make_item(EV_NO_BUTTON, 2328, 3200));
        send_item(make_item(a2r_pkg::EV_RELEASE_LEFT, 0, 0));
        send_item(make_item(a2r_pkg::EV_PRESS_RIGHT, 4096, 9000));
        send_item(make_item(EV_NO_BUTTON, 100, 100));
        send_item(make_item(a2r_pkg::EV_RELEASE_RIGHT, RAW_TOP, 0));
        send_item(make_item(EV_NO_BUTTON, 0, RAW_TOP));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    after_moves  = 4'd0;
                    report_count = 4'd15;
                end
                1:
                begin
                    after_moves  = 4'd15;
                    report_count = 4'd1;
                end
                2:
                begin
                    after_moves  = a2r_pkg::CFG_W'($urandom_range(15));
                    report_count = 4'd0;
                end
                3:
                begin
                    after_moves  = a2r_pkg::CFG_W'($urandom_range(14, 1));
                    report_count = a2r_pkg::CFG_W'($urandom_range(14, 1));
                end
                default:
                begin
                    after_moves  = a2r_pkg::CFG_W'($urandom_range(15));
                    report_count = a2r_pkg::CFG_W'($urandom_range(15));
                end
            endcase
            set_registers(after_moves, report_count);
            calm = (phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 3)
                    drain();
                send_item(random_item());
            end
        end
        drain();
        repeat (40) @(posedge clk);

        $display("covered %0d events and %0d reports: %0d walk steps, %0d homing runs",
                 sb.events, sb.reports_checked, sb.walk_steps, sb.homing_runs);
        $display("under %0d register settings, with one long output hold-off",
                 settings_used);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("absolute_to_relative_mouse_reports_test: done, clean");
        else
            $display("absolute_to_relative_mouse_reports_test: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #30_000_000;
        $display("absolute_to_relative_mouse_reports_test: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/a2r_pkg.sv
design/a2r_seq.sv
design/absolute_to_relative_mouse_reports.sv
dv/absolute_to_relative_mouse_reports_test.sv
